/* src/cfp_pkg.sv */
// Package for the CRC-32 frame parser: result codes, result entry type,
// size constants and the byte-wide reflected CRC-32 update. No dependencies.
package cfp_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES = 256;
  localparam int unsigned HDR_BYTES         = 4;
  localparam int unsigned OVERHEAD_BYTES    = 8;
  localparam int unsigned CRC_BYTES         = 4;
  localparam int unsigned COUNT_W           = 17;
  localparam int unsigned LEN_W             = 16;

  localparam logic [31:0]        CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0]        CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [7:0]         START_RESET  = 8'h02;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_CRC_BAD   = 3'd4
  } status_e;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    status_e          status;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
    logic             end_of_run;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

/* src/cfp_in_if.sv */
// Input channel of the frame parser: one received byte per transaction.
// Depends on nothing.
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

/* src/cfp_out_if.sv */
// Result channel of the frame parser: a payload byte or a frame status
// per transaction. Depends on cfp_pkg for the status type.
interface cfp_out_if
  import cfp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [7:0]       payload_byte;
  status_e          status;
  logic [7:0]       command;
  logic [LEN_W-1:0] length;
  logic             end_of_run;

  modport source (output valid, kind, payload_byte, status, command, length, end_of_run,
                  input ready);
  modport sink   (input valid, kind, payload_byte, status, command, length, end_of_run,
                  output ready);
endinterface

/* src/crc32_frame_parser.sv */
// Top level of the CRC-32 frame parser: header/CRC tracking and a four-entry
// result queue. Depends on cfp_pkg, cfp_in_if and cfp_out_if.
//
//   channel   direction  transaction
//   in_i      sink       data_byte, frame_end
//   out_o     source     kind, payload_byte, status, command, length, end_of_run
//   cfg_*     write      start_byte, taken when cfg_we_i is high
//
// One input byte is taken per cycle while in_i.ready is high; the CRC byte update and the status
// decision are done in the accepting cycle and the results land in the queue.
// A byte yields zero, one or two results; in_i.ready is high while the queue
// holds room for two, so a drained output sustains one byte per cycle.
// Reset clears the frame state, the queue and sets start_byte to 2.
module crc32_frame_parser
  import cfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  cfp_in_if.sink     in_i,
  cfp_out_if.source  out_o
);

  logic [7:0]         start_byte_q;
  logic [COUNT_W-1:0] byte_count_q, byte_count_d;
  logic [31:0]        crc_q, crc_d;
  logic [7:0]         cmd_q, cmd_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [31:0]        rchk_q, rchk_d;
  logic               sbad_q, sbad_d;

  logic [7:0]         b;
  logic [COUNT_W-1:0] data_end;
  logic [COUNT_W:0]   check_end;
  logic [COUNT_W-1:0] chk_off;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W:0]   need_cnt;
  logic               in_data, in_check, emit_pl, last;
  status_e            st;
  result_t            res0, res1;
  logic [1:0]         n_res;

  logic               accept;

  result_t            mem_q [4];
  logic [1:0]         wptr_q, rptr_q;
  logic [2:0]         cnt_q;
  logic               pop;

  assign accept = in_i.valid & in_i.ready;
  assign b      = in_i.data_byte;
  assign last   = in_i.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_RESET;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_data_i;
    end
  end

  always_comb begin
    sbad_d = sbad_q;
    cmd_d  = cmd_q;
    len_d  = len_q;
    case (byte_count_q)
      COUNT_W'(0): sbad_d = (b != start_byte_q);
      COUNT_W'(1): cmd_d  = b;
      COUNT_W'(2): len_d  = {len_q[15:8], b};
      COUNT_W'(3): len_d  = {b, len_q[7:0]};
      default: ;
    endcase

    data_end  = COUNT_W'(HDR_BYTES) + COUNT_W'(len_d);
    check_end = {1'b0, data_end} + (COUNT_W + 1)'(CRC_BYTES);
    in_data   = byte_count_q < data_end;
    in_check  = !in_data && ({1'b0, byte_count_q} < check_end);
    chk_off   = byte_count_q - data_end;

    crc_d  = in_data ? crc_byte(crc_q, b) : crc_q;
    rchk_d = rchk_q;
    if (in_check) begin
      case (chk_off[1:0])
        2'd0:    rchk_d = rchk_q | {24'd0, b};
        2'd1:    rchk_d = rchk_q | {16'd0, b, 8'd0};
        2'd2:    rchk_d = rchk_q | {8'd0, b, 16'd0};
        default: rchk_d = rchk_q | {b, 24'd0};
      endcase
    end

    emit_pl = in_data && (byte_count_q >= COUNT_W'(HDR_BYTES)) && !sbad_d &&
              (COUNT_W'(len_d) <= COUNT_W'(MAX_PAYLOAD_BYTES));

    cnt_inc  = (byte_count_q != COUNT_MAX) ? byte_count_q + COUNT_W'(1) : byte_count_q;
    need_cnt = (COUNT_W + 1)'(OVERHEAD_BYTES) + (COUNT_W + 1)'(len_d);

    if (cnt_inc < COUNT_W'(OVERHEAD_BYTES) || sbad_d) begin
      st = ST_SHORT;
    end else if (COUNT_W'(len_d) > COUNT_W'(MAX_PAYLOAD_BYTES)) begin
      st = ST_TOO_LONG;
    end else if ({1'b0, cnt_inc} < need_cnt) begin
      st = ST_TRUNCATED;
    end else if (rchk_d != (crc_d ^ CRC_ALL_ONES)) begin
      st = ST_CRC_BAD;
    end else begin
      st = ST_OK;
    end

    res0.kind         = KIND_PAYLOAD;
    res0.payload_byte = b;
    res0.status       = ST_OK;
    res0.command      = cmd_d;
    res0.length       = len_d;
    res0.end_of_run   = !last;
    res1.kind         = KIND_STATUS;
    res1.payload_byte = 8'd0;
    res1.status       = st;
    res1.command      = cmd_d;
    res1.length       = len_d;
    res1.end_of_run   = 1'b1;
    n_res = {1'b0, emit_pl} + {1'b0, last};
    if (!emit_pl) begin
      res0 = res1;
    end

    byte_count_d = cnt_inc;
    if (last) begin
      byte_count_d = '0;
      crc_d        = CRC_ALL_ONES;
      cmd_d        = 8'd0;
      len_d        = '0;
      rchk_d       = 32'd0;
      sbad_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q        <= CRC_ALL_ONES;
      cmd_q        <= 8'd0;
      len_q        <= '0;
      rchk_q       <= 32'd0;
      sbad_q       <= 1'b0;
    end else if (accept) begin
      byte_count_q <= byte_count_d;
      crc_q        <= crc_d;
      cmd_q        <= cmd_d;
      len_q        <= len_d;
      rchk_q       <= rchk_d;
      sbad_q       <= sbad_d;
    end
  end

  // result queue
  assign in_i.ready = (cnt_q <= 3'd2);
  assign pop        = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      mem_q[wptr_q] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      mem_q[wptr_q + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      if (accept) begin
        wptr_q <= wptr_q + n_res;
      end
      if (pop) begin
        rptr_q <= rptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
    end
  end

  assign out_o.valid        = (cnt_q != 3'd0);
  assign out_o.kind         = mem_q[rptr_q].kind;
  assign out_o.payload_byte = mem_q[rptr_q].payload_byte;
  assign out_o.status       = mem_q[rptr_q].status;
  assign out_o.command      = mem_q[rptr_q].command;
  assign out_o.length       = mem_q[rptr_q].length;
  assign out_o.end_of_run   = mem_q[rptr_q].end_of_run;

endmodule

/* tb/crc32_frame_parser_tb.sv */
// Self-checking testbench for crc32_frame_parser: directed and random frames,
// a byte-level predictor of payload and status transactions, randomized flow.
// Depends on cfp_pkg, cfp_in_if, cfp_out_if and the crc32_frame_parser RTL.
module crc32_frame_parser_tb;
  import cfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } rx_byte_t;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PATTERN,
    RDY_SPARSE
  } ready_mode_e;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  cfp_in_if  in_bus ();
  cfp_out_if out_bus ();

  crc32_frame_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  rx_byte_t rx_bytes[$];
  result_t  results_due[$];
  result_t  due;
  rx_byte_t next_byte;

  int unsigned mismatches = 0;
  int unsigned bytes_queued = 0;

  // predictor state
  logic [7:0]         start_cfg;
  logic [COUNT_W-1:0] frame_count;
  logic [31:0]        crc_acc;
  logic [7:0]         held_cmd;
  logic [LEN_W-1:0]   held_len;
  logic [31:0]        rx_crc;
  logic               start_bad;

  // driver and receiver state
  logic        in_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  ready_mode_e ready_mode = RDY_ALWAYS;
  int unsigned mode_left = 0;
  logic [7:0]  stall_pat = 8'h01;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] acc;
    acc = c;
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ d[i]) acc = (acc >> 1) ^ CRC_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  function automatic void clear_frame();
    frame_count = '0;
    crc_acc     = CRC_ALL_ONES;
    held_cmd    = '0;
    held_len    = '0;
    rx_crc      = '0;
    start_bad   = 1'b0;
  endfunction

  function automatic void push_result(input logic kind, input logic [7:0] pb, input status_e st);
    result_t r;
    r.kind         = kind;
    r.payload_byte = pb;
    r.status       = st;
    r.command      = held_cmd;
    r.length       = held_len;
    r.end_of_run   = 1'b0;
    results_due.push_back(r);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    int unsigned data_end;
    int unsigned base;
    status_e     st;
    pos  = frame_count;
    base = results_due.size();
    if (pos == 0) start_bad = (b != start_cfg);
    else if (pos == 1) held_cmd = b;
    else if (pos == 2) held_len[7:0] = b;
    else if (pos == 3) held_len[15:8] = b;
    data_end = HDR_BYTES + held_len;
    if (pos < data_end) begin
      crc_acc = crc32_next(crc_acc, b);
      if (pos >= HDR_BYTES && !start_bad && held_len <= MAX_PAYLOAD_BYTES)
        push_result(KIND_PAYLOAD, b, ST_OK);
    end else if (pos < data_end + CRC_BYTES) begin
      rx_crc = rx_crc | ({24'd0, b} << (8 * (pos - data_end)));
    end
    if (frame_count != COUNT_MAX) frame_count = frame_count + 1'b1;
    if (last) begin
      if (frame_count < OVERHEAD_BYTES || start_bad) st = ST_SHORT;
      else if (held_len > MAX_PAYLOAD_BYTES) st = ST_TOO_LONG;
      else if (frame_count < OVERHEAD_BYTES + held_len) st = ST_TRUNCATED;
      else if (rx_crc != ~crc_acc) st = ST_CRC_BAD;
      else st = ST_OK;
      push_result(KIND_STATUS, 8'h00, st);
      clear_frame();
    end
    if (results_due.size() > base) results_due[results_due.size() - 1].end_of_run = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // prediction on input transactions, checking on output transactions
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_bus.valid && in_bus.ready;
    if (in_taken) deframe_byte(in_bus.data_byte, in_bus.frame_end);
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transaction: kind %0b status %0d", out_bus.kind,
               out_bus.status);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        check_field("kind", due.kind, out_bus.kind);
        check_field("payload_byte", due.payload_byte, out_bus.payload_byte);
        check_field("status", due.status, out_bus.status);
        check_field("command", due.command, out_bus.command);
        check_field("length", due.length, out_bus.length);
        check_field("end_of_run", due.end_of_run, out_bus.end_of_run);
      end
    end
  end

  // byte driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_bus.valid || in_taken)) begin
      if (gap_left > 0) begin
        in_bus.valid <= 1'b0;
        gap_left--;
      end else if (rx_bytes.size() > 0) begin
        next_byte = rx_bytes.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= next_byte.data_byte;
        in_bus.frame_end <= next_byte.frame_end;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 160);
      stall_pat  = 8'($urandom) | 8'h01;
    end else begin
      mode_left--;
    end
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    case (ready_mode)
      RDY_ALWAYS:  out_bus.ready <= 1'b1;
      RDY_COIN:    out_bus.ready <= 1'($urandom_range(0, 1));
      RDY_PATTERN: out_bus.ready <= stall_pat[0];
      default:     out_bus.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    rx_byte_t item;
    item.data_byte = b;
    item.frame_end = last;
    rx_bytes.push_back(item);
    bytes_queued++;
  endtask

  // keep == 0 sends the whole frame, otherwise it is cut or padded to keep bytes
  task automatic push_frame(input logic [7:0] lead, input logic [7:0] cmd,
                            input int unsigned len, input int unsigned keep,
                            input int unsigned extra, input bit flip);
    logic [7:0]  fb[$];
    logic [31:0] crc;
    int unsigned k;
    fb.push_back(lead);
    fb.push_back(cmd);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    if (len <= 300) begin
      for (k = 0; k < len; k++) fb.push_back(8'($urandom));
      crc = CRC_ALL_ONES;
      foreach (fb[j]) crc = crc32_next(crc, fb[j]);
      crc = ~crc;
      for (k = 0; k < CRC_BYTES; k++) fb.push_back(crc[8*k +: 8]);
    end
    if (flip) begin
      k = $urandom_range(HDR_BYTES, fb.size() - 1);
      fb[k] = fb[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (keep != 0) begin
      while (fb.size() > keep) void'(fb.pop_back());
      while (fb.size() < keep) fb.push_back(8'($urandom));
    end
    for (k = 0; k < extra; k++) fb.push_back(8'($urandom));
    foreach (fb[j]) push_byte(fb[j], j == fb.size() - 1);
  endtask

  task automatic random_frames(input int unsigned n_bytes);
    int unsigned first;
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    logic [7:0]  cmd;
    first = bytes_queued;
    while (bytes_queued - first < n_bytes) begin
      pick = $urandom_range(0, 99);
      cmd  = 8'($urandom);
      len  = $urandom_range(0, 12);
      if ($urandom_range(0, 14) == 0) len = $urandom_range(13, MAX_PAYLOAD_BYTES);
      if ($urandom_range(0, 39) == 0) len = MAX_PAYLOAD_BYTES;
      if (pick < 55) begin
        push_frame(start_cfg, cmd, len, 0,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
      end else if (pick < 67) begin
        push_frame(start_cfg, cmd, len, 0, 0, 1'b1);
      end else if (pick < 77) begin
        push_frame(start_cfg, cmd, len, $urandom_range(1, len + OVERHEAD_BYTES - 1), 0, 1'b0);
      end else if (pick < 85) begin
        push_frame(start_cfg ^ 8'($urandom_range(1, 255)), cmd, len, 0, 0, 1'b0);
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0:       len = MAX_PAYLOAD_BYTES + 1;
          1:       len = 65535;
          default: len = $urandom_range(MAX_PAYLOAD_BYTES + 2, 65534);
        endcase
        push_frame(start_cfg, cmd, len, $urandom_range(HDR_BYTES, 12), 0, 1'b0);
      end else begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
          push_byte(8'($urandom), (k == n - 1) || ($urandom_range(0, 4) == 0));
      end
    end
  endtask

  task automatic settle();
    while (rx_bytes.size() != 0 || in_bus.valid || results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    start_cfg = v;
  endtask

  initial begin
    cfg_we_i         = 1'b0;
    cfg_data_i       = 8'h00;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.frame_end = 1'b0;
    out_bus.ready    = 1'b0;
    start_cfg        = START_RESET;
    clear_frame();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // good frame with a trailing byte, over-limit length, payload on the last
    // byte, and a one-byte frame with a wrong start byte
    push_frame(start_cfg, 8'hFF, 0, 0, 1, 1'b0);
    push_frame(start_cfg, 8'h00, 65535, 8, 0, 1'b0);
    push_frame(start_cfg, 8'($urandom), 1, 5, 0, 1'b0);
    push_byte(start_cfg ^ 8'h01, 1'b1);
    settle();

    write_start(8'h00);
    random_frames(300);
    settle();

    write_start(8'hFF);
    random_frames(300);
    settle();

    write_start(8'($urandom));
    random_frames(300);
    settle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/cfp_pkg.sv
src/cfp_in_if.sv
src/cfp_out_if.sv
src/crc32_frame_parser.sv
tb/crc32_frame_parser_tb.sv
